/* rtl/core/rti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

   // coordinate and register width, Q8.8 by default
   localparam int CRD_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DIST_W = 32;

   localparam int COORD_FRAC_BITS_DEF = 8;
   localparam int DIST_FRAC_BITS_DEF = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

/* rtl/core/ray_triangle_intersect_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel     | Direction | Handshake            | Payload
// ------------+-----------+----------------------+------------------------------------
// req         | in        | req_valid/req_stall  | req_vert_{a,b,c}_{x,y,z}, signed Q8.8
// rsp         | out       | rsp_valid/rsp_stall  | rsp_hit, rsp_hit_distance (Q16.16)
// csr         | in        | csr_write            | csr_index, csr_data (16 bits)
//
// One transaction enters per cycle unless stalled; each yields one result through
// 7 arithmetic stages, 32 divider stages of one quotient bit each, output register.
// The whole pipeline advances together; it holds only while a result sits in the
// output register and rsp_stall is high, so throughput is one triangle per cycle.
// Reset is synchronous: it clears all valid bits and loads the ray registers
// (origin 0, direction +z of length 1.0). Write csr only while the pipe is empty.

module ray_triangle_intersect_top
   import rti_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int DIST_FRAC_BITS  = DIST_FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [CRD_W-1:0] req_vert_a_x,
   input  wire logic signed [CRD_W-1:0] req_vert_a_y,
   input  wire logic signed [CRD_W-1:0] req_vert_a_z,
   input  wire logic signed [CRD_W-1:0] req_vert_b_x,
   input  wire logic signed [CRD_W-1:0] req_vert_b_y,
   input  wire logic signed [CRD_W-1:0] req_vert_b_z,
   input  wire logic signed [CRD_W-1:0] req_vert_c_x,
   input  wire logic signed [CRD_W-1:0] req_vert_c_y,
   input  wire logic signed [CRD_W-1:0] req_vert_c_z,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_hit,
   output logic [DIST_W-1:0]            rsp_hit_distance,
   input  wire logic                    csr_write,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CRD_W-1:0]        csr_data
);

   localparam int DIFF_W = CRD_W + 1;       // edge / origin difference
   localparam int PROD_W = 2 * DIFF_W;      // one cross-product term
   localparam int CRS_W  = PROD_W + 1;      // cross-product component
   localparam int ACC_W  = 54;              // dot products, det, u, v, t
   localparam int DEN_W  = ACC_W - 1;       // |det|, also remainder width
   localparam int SH     = DIST_W - DIST_FRAC_BITS;
   localparam int CMP_W  = DEN_W + SH + 1;
   localparam int NSTG   = DIST_W;          // divider stages
   localparam logic [CRD_W-1:0] DIR_Z_RST = CRD_W'(1) << COORD_FRAC_BITS;

   // ---------------- ray registers ----------------
   logic signed [CRD_W-1:0] org_ff [3];
   logic signed [CRD_W-1:0] dir_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= DIR_Z_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_X: org_ff[0] <= csr_data;
            CSR_ORIGIN_Y: org_ff[1] <= csr_data;
            CSR_ORIGIN_Z: org_ff[2] <= csr_data;
            CSR_DIR_X:    dir_ff[0] <= csr_data;
            CSR_DIR_Y:    dir_ff[1] <= csr_data;
            CSR_DIR_Z:    dir_ff[2] <= csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------- global advance ----------------
   // Every stage moves together; hold everything while the output waits.
   logic adv;
   logic rsp_valid_ff;
   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // ---------------- S1: edges and origin offset ----------------
   logic signed [CRD_W-1:0]  va [3], vb [3], vc [3];
   logic signed [DIFF_W-1:0] e1_ff [3], e2_ff [3], s1_ff [3];
   logic                     v1_ff;

   assign va = '{req_vert_a_x, req_vert_a_y, req_vert_a_z};
   assign vb = '{req_vert_b_x, req_vert_b_y, req_vert_b_z};
   assign vc = '{req_vert_c_x, req_vert_c_y, req_vert_c_z};

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
            e2_ff[i] <= DIFF_W'(vc[i]) - DIFF_W'(va[i]);
            s1_ff[i] <= DIFF_W'(org_ff[i]) - DIFF_W'(va[i]);
         end
      end
   end

   // ---------------- S2: cross-product terms ----------------
   // Terms of cross(a,b): pair 2i/2i+1 gives component i as difference.
   logic signed [PROD_W-1:0] mn_ff [6], mu_ff [6], mv_ff [6];
   logic signed [DIFF_W-1:0] s2_ff [3];
   logic                     v2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // normal = cross(e1, e2)
         mn_ff[0] <= e1_ff[1] * e2_ff[2];  mn_ff[1] <= e1_ff[2] * e2_ff[1];
         mn_ff[2] <= e1_ff[2] * e2_ff[0];  mn_ff[3] <= e1_ff[0] * e2_ff[2];
         mn_ff[4] <= e1_ff[0] * e2_ff[1];  mn_ff[5] <= e1_ff[1] * e2_ff[0];
         // cross(s, e2)
         mu_ff[0] <= s1_ff[1] * e2_ff[2];  mu_ff[1] <= s1_ff[2] * e2_ff[1];
         mu_ff[2] <= s1_ff[2] * e2_ff[0];  mu_ff[3] <= s1_ff[0] * e2_ff[2];
         mu_ff[4] <= s1_ff[0] * e2_ff[1];  mu_ff[5] <= s1_ff[1] * e2_ff[0];
         // cross(e1, s)
         mv_ff[0] <= e1_ff[1] * s1_ff[2];  mv_ff[1] <= e1_ff[2] * s1_ff[1];
         mv_ff[2] <= e1_ff[2] * s1_ff[0];  mv_ff[3] <= e1_ff[0] * s1_ff[2];
         mv_ff[4] <= e1_ff[0] * s1_ff[1];  mv_ff[5] <= e1_ff[1] * s1_ff[0];
         s2_ff <= s1_ff;
      end
   end

   // ---------------- S3: cross-product components ----------------
   logic signed [CRS_W-1:0]  n_ff [3], pu_ff [3], pv_ff [3];
   logic signed [DIFF_W-1:0] s3_ff [3];
   logic                     v3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i]  <= CRS_W'(mn_ff[2*i]) - CRS_W'(mn_ff[2*i+1]);
            pu_ff[i] <= CRS_W'(mu_ff[2*i]) - CRS_W'(mu_ff[2*i+1]);
            pv_ff[i] <= CRS_W'(mv_ff[2*i]) - CRS_W'(mv_ff[2*i+1]);
         end
         s3_ff <= s2_ff;
      end
   end

   // ---------------- S4: dot-product terms ----------------
   logic signed [CRD_W+CRS_W-1:0]  dn_ff [3], du_ff [3], dv_ff [3];
   logic signed [DIFF_W+CRS_W-1:0] sn_ff [3];
   logic                           v4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dn_ff[i] <= dir_ff[i] * n_ff[i];
            du_ff[i] <= dir_ff[i] * pu_ff[i];
            dv_ff[i] <= dir_ff[i] * pv_ff[i];
            sn_ff[i] <= s3_ff[i] * n_ff[i];
         end
      end
   end

   // ---------------- S5: sums ----------------
   logic signed [ACC_W-1:0] det5_ff, u5_ff, v5_ff, t5_ff;
   logic                    v5_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det5_ff <= ACC_W'(dn_ff[0]) + ACC_W'(dn_ff[1]) + ACC_W'(dn_ff[2]);
         u5_ff   <= ACC_W'(du_ff[0]) + ACC_W'(du_ff[1]) + ACC_W'(du_ff[2]);
         v5_ff   <= ACC_W'(dv_ff[0]) + ACC_W'(dv_ff[1]) + ACC_W'(dv_ff[2]);
         t5_ff   <= ACC_W'(sn_ff[0]) + ACC_W'(sn_ff[1]) + ACC_W'(sn_ff[2]);
      end
   end

   // ---------------- S6: fold the determinant sign ----------------
   logic                    neg5;
   logic [DEN_W-1:0]        den6_ff;
   logic signed [ACC_W-1:0] u6_ff, v6_ff, t6_ff;
   logic                    nz6_ff, v6_vld_ff;

   assign neg5 = det5_ff[ACC_W-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         den6_ff <= DEN_W'(neg5 ? -det5_ff : det5_ff);
         u6_ff   <= neg5 ? -u5_ff : u5_ff;
         v6_ff   <= neg5 ? -v5_ff : v5_ff;
         t6_ff   <= neg5 ? t5_ff : -t5_ff;   // t is the raw dot product negated unless det < 0
         nz6_ff  <= (det5_ff != '0);
      end
   end

   // ---------------- S7: hit test, overflow, divider setup ----------------
   logic signed [ACC_W:0] uv_sum;
   logic [CMP_W-1:0]      sat_lim, t_ext;
   logic                  hit_in, sat_in;

   assign uv_sum  = (ACC_W+1)'(u6_ff) + (ACC_W+1)'(v6_ff);
   assign sat_lim = CMP_W'(den6_ff) << SH;
   assign t_ext   = CMP_W'(t6_ff[DEN_W-1:0]);
   assign hit_in  = nz6_ff && !u6_ff[ACC_W-1] && !v6_ff[ACC_W-1] && !t6_ff[ACC_W-1]
                    && (uv_sum <= $signed({2'b00, den6_ff}));
   assign sat_in  = (t_ext >= sat_lim);

   // divider pipeline: index 0 is loaded here, index k holds k quotient bits
   logic [DEN_W-1:0]  dq_rem_ff [NSTG+1];
   logic [DEN_W-1:0]  dq_den_ff [NSTG+1];
   logic [DIST_W-1:0] dq_low_ff [NSTG+1];
   logic [DIST_W-1:0] dq_quo_ff [NSTG+1];
   logic              dq_hit_ff [NSTG+1];
   logic              dq_sat_ff [NSTG+1];
   logic              dq_vld_ff [NSTG+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dq_rem_ff[0] <= DEN_W'(t6_ff[DEN_W-1:0] >> SH);
         dq_den_ff[0] <= den6_ff;
         dq_low_ff[0] <= DIST_W'({t6_ff[DEN_W-1:0], {DIST_FRAC_BITS{1'b0}}});
         dq_quo_ff[0] <= '0;
         dq_hit_ff[0] <= hit_in;
         dq_sat_ff[0] <= sat_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 1; k <= NSTG; k++) begin : g_div
      logic [DEN_W:0] cand;
      logic           ge;
      assign cand = {dq_rem_ff[k-1], dq_low_ff[k-1][DIST_W-1]};
      assign ge   = (cand >= {1'b0, dq_den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (adv) begin
            dq_rem_ff[k] <= DEN_W'(ge ? cand - {1'b0, dq_den_ff[k-1]} : cand);
            dq_den_ff[k] <= dq_den_ff[k-1];
            dq_low_ff[k] <= dq_low_ff[k-1] << 1;
            dq_quo_ff[k] <= {dq_quo_ff[k-1][DIST_W-2:0], ge};
            dq_hit_ff[k] <= dq_hit_ff[k-1];
            dq_sat_ff[k] <= dq_sat_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dq_vld_ff[k] <= dq_vld_ff[k-1];
         end
      end
   end

   // ---------------- front valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_vld_ff    <= 1'b0;
         v6_vld_ff    <= 1'b0;
         dq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_vld_ff    <= v4_ff;
         v6_vld_ff    <= v5_vld_ff;
         dq_vld_ff[0] <= v6_vld_ff;
      end
   end

   // ---------------- output register ----------------
   logic              rsp_hit_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dq_vld_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= dq_hit_ff[NSTG];
         priority if (!dq_hit_ff[NSTG]) begin
            rsp_dist_ff <= '0;
         end else if (dq_sat_ff[NSTG]) begin
            rsp_dist_ff <= '1;
         end else begin
            rsp_dist_ff <= dq_quo_ff[NSTG];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_distance = rsp_dist_ff;

   // ---------------- assertions ----------------
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_distance == '0)
      else $error("miss with nonzero distance");

   a_hit_den: assert property (@(posedge clock) disable iff (reset)
      dq_vld_ff[0] && dq_hit_ff[0] |-> dq_den_ff[0] != '0)
      else $error("hit with zero determinant");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      adv && dq_vld_ff[NSTG] |=> rsp_valid)
      else $error("result lost at output register");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dq_vld_ff[NSTG]) && $stable(rsp_hit))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import rti_pkg::*;

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Block ports
   // ------------------------------------------------------------------
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [CRD_W-1:0] req_vert_a_x = '0, req_vert_a_y = '0, req_vert_a_z = '0;
   logic signed [CRD_W-1:0] req_vert_b_x = '0, req_vert_b_y = '0, req_vert_b_z = '0;
   logic signed [CRD_W-1:0] req_vert_c_x = '0, req_vert_c_y = '0, req_vert_c_z = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b1;
   logic                    rsp_hit;
   logic [DIST_W-1:0]       rsp_hit_distance;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CRD_W-1:0]        csr_data = '0;

   ray_triangle_intersect_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vert_a_x     (req_vert_a_x),
      .req_vert_a_y     (req_vert_a_y),
      .req_vert_a_z     (req_vert_a_z),
      .req_vert_b_x     (req_vert_b_x),
      .req_vert_b_y     (req_vert_b_y),
      .req_vert_b_z     (req_vert_b_z),
      .req_vert_c_x     (req_vert_c_x),
      .req_vert_c_y     (req_vert_c_y),
      .req_vert_c_z     (req_vert_c_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_hit_distance (rsp_hit_distance),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ------------------------------------------------------------------
   // Types, ray copy and expected-result store
   // ------------------------------------------------------------------
   typedef logic signed [CRD_W-1:0] coord_t;

   typedef struct packed {
      coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_t;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_dist;
   } intersect_t;

   // directed row: triangle plus an optional typed-in result
   typedef struct packed {
      triangle_t  shape;
      logic       fixed_exp;
      intersect_t exp;
   } vector_row_t;

   localparam int LATENCY    = 40;
   localparam int WDOG_LIMIT = 4000;
   localparam logic [DIST_W-1:0] DIST_SAT = '1;

   coord_t     ray_org [3];
   coord_t     ray_dir [3];
   intersect_t hit_queue [$];

   int n_sent      = 0;
   int n_checked   = 0;
   int n_hits      = 0;
   int n_sat       = 0;
   int n_mismatch  = 0;
   int idle_cycles = 0;

   // ------------------------------------------------------------------
   // Intersection predictor: exact 64-bit integer Moller-Trumbore
   // ------------------------------------------------------------------
   function automatic intersect_t predict_hit(triangle_t tr);
      longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, det, sx, sy, sz;
      longint sg, px, py, pz, u, v, t, whole, rem, q;
      intersect_t r;
      r = '0;
      e1x = tr.bx - tr.ax; e1y = tr.by - tr.ay; e1z = tr.bz - tr.az;
      e2x = tr.cx - tr.ax; e2y = tr.cy - tr.ay; e2z = tr.cz - tr.az;
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      det = ray_dir[0] * nx + ray_dir[1] * ny + ray_dir[2] * nz;
      if (det == 0) return r;               // parallel ray or degenerate triangle
      sg = (det > 0) ? 1 : -1;
      if (det < 0) det = -det;
      sx = ray_org[0] - tr.ax; sy = ray_org[1] - tr.ay; sz = ray_org[2] - tr.az;
      px = sy * e2z - sz * e2y;
      py = sz * e2x - sx * e2z;
      pz = sx * e2y - sy * e2x;
      u = sg * (ray_dir[0] * px + ray_dir[1] * py + ray_dir[2] * pz);
      px = e1y * sz - e1z * sy;
      py = e1z * sx - e1x * sz;
      pz = e1x * sy - e1y * sx;
      v = sg * (ray_dir[0] * px + ray_dir[1] * py + ray_dir[2] * pz);
      t = -sg * (sx * nx + sy * ny + sz * nz);
      if (u >= 0 && v >= 0 && u + v <= det && t >= 0) begin
         r.hit = 1'b1;
         whole = t / det;
         rem   = t % det;
         if (whole >= (64'sd1 << (DIST_W - DIST_FRAC_BITS_DEF))) begin
            r.hit_dist = DIST_SAT;
         end else begin
            q = whole;
            for (int i = 0; i < DIST_FRAC_BITS_DEF; i++) begin
               rem = rem << 1;
               q   = q << 1;
               if (rem >= det) begin
                  rem = rem - det;
                  q   = q | 1;
               end
            end
            r.hit_dist = q[DIST_W-1:0];
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Ray register write: mirror into the predictor copy
   // ------------------------------------------------------------------
   task automatic write_ray_reg(csr_index_type idx, logic [CRD_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ORIGIN_X: ray_org[0] = val;
         CSR_ORIGIN_Y: ray_org[1] = val;
         CSR_ORIGIN_Z: ray_org[2] = val;
         CSR_DIR_X:    ray_dir[0] = val;
         CSR_DIR_Y:    ray_dir[1] = val;
         CSR_DIR_Z:    ray_dir[2] = val;
         default: ;
      endcase
   endtask

   task automatic load_ray(coord_t ox, coord_t oy, coord_t oz,
                           coord_t dx, coord_t dy, coord_t dz);
      write_ray_reg(CSR_ORIGIN_X, ox);
      write_ray_reg(CSR_ORIGIN_Y, oy);
      write_ray_reg(CSR_ORIGIN_Z, oz);
      write_ray_reg(CSR_DIR_X, dx);
      write_ray_reg(CSR_DIR_Y, dy);
      write_ray_reg(CSR_DIR_Z, dz);
   endtask

   // Drain: wait for every expected result, then let the pipe settle.
   task automatic drain_pipe();
      wait (hit_queue.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: present one transaction, hold it until accepted
   // ------------------------------------------------------------------
   task automatic send_triangle(triangle_t tr);
      req_valid    <= 1'b1;
      req_vert_a_x <= tr.ax; req_vert_a_y <= tr.ay; req_vert_a_z <= tr.az;
      req_vert_b_x <= tr.bx; req_vert_b_y <= tr.by; req_vert_b_z <= tr.bz;
      req_vert_c_x <= tr.cx; req_vert_c_y <= tr.cy; req_vert_c_z <= tr.cz;
      do @(posedge clock); while (req_stall);
      // accepted at this edge; expectation uses the ray in force now
      hit_queue.push_back(predict_hit(tr));
      n_sent++;
      @(negedge clock);
   endtask

   // Burst sender: random burst lengths, random gaps; gaps zero at times.
   int burst_left = 0;
   task automatic send_paced(triangle_t tr);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      send_triangle(tr);
   endtask

   function automatic coord_t rnd_coord();
      case ($urandom_range(0, 5))
         0:       return coord_t'($urandom);                       // full range
         1:       return coord_t'($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
         default: return coord_t'($signed($urandom_range(0, 4095)) - 2048);
      endcase
   endfunction

   function automatic coord_t near(coord_t c, int spread);
      return coord_t'(c + $signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // Triangle built around the ray so that many transactions hit.
   function automatic triangle_t aimed_triangle();
      triangle_t tr;
      coord_t    px, py, pz;
      int        k, s;
      k  = $urandom_range(0, 16);
      s  = $urandom_range(16, 1200);
      px = coord_t'(ray_org[0] + ((ray_dir[0] * k) >>> 2));
      py = coord_t'(ray_org[1] + ((ray_dir[1] * k) >>> 2));
      pz = coord_t'(ray_org[2] + ((ray_dir[2] * k) >>> 2));
      tr.ax = near(px, s); tr.ay = near(py, s); tr.az = near(pz, s);
      tr.bx = near(px, s); tr.by = near(py, s); tr.bz = near(pz, s);
      tr.cx = near(px, s); tr.cy = near(py, s); tr.cz = near(pz, s);
      return tr;
   endfunction

   function automatic triangle_t random_triangle();
      triangle_t tr;
      tr.ax = rnd_coord(); tr.ay = rnd_coord(); tr.az = rnd_coord();
      tr.bx = rnd_coord(); tr.by = rnd_coord(); tr.bz = rnd_coord();
      tr.cx = rnd_coord(); tr.cy = rnd_coord(); tr.cz = rnd_coord();
      if ($urandom_range(0, 9) == 0) begin
         tr.cx = tr.bx; tr.cy = tr.by; tr.cz = tr.bz;            // degenerate
      end
      return tr;
   endfunction

   // ------------------------------------------------------------------
   // Directed table (reset ray: origin 0, direction +z of length 1.0)
   // ------------------------------------------------------------------
   localparam coord_t ONE = 16'sd256;
   localparam coord_t MAXC = 16'sh7FFF;
   localparam coord_t MINC = 16'sh8000;

   vector_row_t directed_rows [] = '{
      // hit straight ahead at z = 1.0, distance 1.0
      '{'{-ONE, -ONE, ONE, ONE, -ONE, ONE, 16'sd0, ONE, ONE}, 1'b1, '{1'b1, 32'h0001_0000}},
      // same triangle, opposite winding
      '{'{-ONE, -ONE, ONE, 16'sd0, ONE, ONE, ONE, -ONE, ONE}, 1'b1, '{1'b1, 32'h0001_0000}},
      // behind the origin: miss
      '{'{-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 16'sd0, ONE, -ONE}, 1'b1, '{1'b0, 32'h0}},
      // triangle through the origin: distance 0
      '{'{-ONE, -ONE, 16'sd0, ONE, -ONE, 16'sd0, 16'sd0, ONE, 16'sd0}, 1'b1, '{1'b1, 32'h0}},
      // parallel to the ray (plane x = 0): miss
      '{'{16'sd0, -ONE, 16'sd0, 16'sd0, ONE, 16'sd0, 16'sd0, 16'sd0, ONE}, 1'b1, '{1'b0, 32'h0}},
      // degenerate, all vertices equal
      '{'{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1, '{1'b0, 32'h0}},
      // collinear vertices
      '{'{16'sd0, 16'sd0, ONE, ONE, ONE, ONE, 16'sd512, 16'sd512, ONE}, 1'b1, '{1'b0, 32'h0}},
      // offset to the side: miss
      '{'{ONE, ONE, ONE, 16'sd768, ONE, ONE, ONE, 16'sd768, ONE}, 1'b1, '{1'b0, 32'h0}},
      // hit on an edge
      '{'{16'sd0, -ONE, ONE, 16'sd0, ONE, ONE, ONE, 16'sd0, ONE}, 1'b1, '{1'b1, 32'h0001_0000}},
      // hit on a vertex
      '{'{16'sd0, 16'sd0, ONE, ONE, 16'sd0, ONE, 16'sd0, ONE, ONE}, 1'b1, '{1'b1, 32'h0001_0000}},
      // far plane at max z, huge triangle
      '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, 16'sd0, MAXC, MAXC}, 1'b0, '0},
      // extremes on every field
      '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC}, 1'b0, '0},
      '{'{MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
        '{1'b0, 32'h0}},
      '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
          16'sh5555, 16'shAAAA}, 1'b0, '0}
   };

   // ------------------------------------------------------------------
   // Receiver: stall on its own pattern (runs, random, and none at all)
   // ------------------------------------------------------------------
   int stall_mode = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;                              // free-flowing
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (stall_left % 7) < 5;               // long blocks
      endcase
   end

   // ------------------------------------------------------------------
   // Checker: compare each accepted result with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      intersect_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_queue.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("ERROR: unexpected result hit=%0b dist=%h", rsp_hit, rsp_hit_distance);
         end else begin
            want = hit_queue.pop_front();
            n_checked++;
            if (want.hit) n_hits++;
            if (want.hit && want.hit_dist == DIST_SAT) n_sat++;
            if (rsp_hit !== want.hit || rsp_hit_distance !== want.hit_dist) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("ERROR: result %0d hit exp %0b got %0b, dist exp %h got %h",
                           n_checked, want.hit, rsp_hit, want.hit_dist, rsp_hit_distance);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles in which no transaction moves on either side
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results pending",
                  idle_cycles, hit_queue.size());
         $display("FAIL ray_triangle_intersect_top");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      intersect_t got_exp;
      triangle_t  tr;
      ray_org = '{16'sd0, 16'sd0, 16'sd0};
      ray_dir = '{16'sd0, 16'sd0, ONE};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows against the reset ray; typed-in results where obvious.
      foreach (directed_rows[i]) begin
         send_triangle(directed_rows[i].shape);
         if (directed_rows[i].fixed_exp) begin
            got_exp = hit_queue[hit_queue.size() - 1];
            if (got_exp !== directed_rows[i].exp) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("ERROR: directed row %0d predictor disagrees with table", i);
            end
            hit_queue[hit_queue.size() - 1] = directed_rows[i].exp;
         end
      end
      req_valid <= 1'b0;
      drain_pipe();

      // Far hit with a tiny direction: distance near the top of the range.
      load_ray(16'sd0, 16'sd0, MINC, 16'sd0, 16'sd0, 16'sd1);
      send_triangle('{-ONE, -ONE, MAXC, ONE, -ONE, MAXC, 16'sd0, ONE, MAXC});
      req_valid <= 1'b0;
      drain_pipe();

      // Random phases, each with its own ray, extremes among them.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0:       load_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC);
            1:       load_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC);
            2:       load_ray(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
            3:       load_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, -ONE, 16'sd0);
            default: load_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                              rnd_coord(), rnd_coord(), rnd_coord());
         endcase
         for (int i = 0; i < 118; i++) begin
            tr = ($urandom_range(0, 9) < 7) ? aimed_triangle() : random_triangle();
            send_paced(tr);
         end
         req_valid <= 1'b0;
         burst_left = 0;
         drain_pipe();
      end

      $display("covered %0d triangles over 14 ray settings: %0d results checked,",
               n_sent, n_checked);
      $display("%0d hits, %0d saturated distances, %0d mismatches",
               n_hits, n_sat, n_mismatch);
      if (n_mismatch == 0 && hit_queue.size() == 0)
         $display("PASS ray_triangle_intersect_top");
      else
         $display("FAIL ray_triangle_intersect_top");
      $finish;
   end

endmodule

/* ray_triangle_intersect_top.f */
rtl/core/rti_pkg.sv
rtl/core/ray_triangle_intersect_top.sv
dv/tb_top.sv
